// ----- src/anp_pkg.sv -----
// Shared types and constants for the AML name string parser.
`timescale 1ns / 1ps
`default_nettype none
package anp_pkg;

	localparam logic [7:0] NULL_NAME_BYTE  = 8'h00;
	localparam logic [7:0] DUAL_NAME_BYTE  = 8'h2E;
	localparam logic [7:0] MULTI_NAME_BYTE = 8'h2F;
	localparam logic [7:0] ROOT_BYTE       = 8'h5C;
	localparam logic [7:0] PARENT_BYTE     = 8'h5E;

	localparam int TOK_DEPTH = 4;
	localparam int TOK_PTR_W = $clog2(TOK_DEPTH);
	localparam int TOK_CNT_W = $clog2(TOK_DEPTH + 1);

	localparam int RES_DEPTH = 2;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	typedef enum logic [2:0] {
		KIND_ROOT,
		KIND_PARENT,
		KIND_DUAL,
		KIND_MULTI,
		KIND_NULL,
		KIND_LEAD,
		KIND_OTHER
	} tok_kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_CHAR,
		ST_TRUNC,
		ST_NOT_NAME
	} status_t;

	typedef struct packed {
		logic [7:0] data;
		logic       stream_end;
		tok_kind_t  kind;
		logic       is_lead;
		logic       is_segch;
	} tok_t;

	typedef struct packed {
		logic        root_flag;
		logic [7:0]  parent_count;
		logic [7:0]  segment_count;
		logic [7:0]  segment_index;
		logic [31:0] segment_chars;
		logic        has_segment;
		logic        segment_valid;
		logic        last_of_name;
		status_t     status;
	} res_t;

endpackage
`default_nettype wire

// ----- src/anp_front.sv -----
// Front end: classifies each incoming byte and queues it for the parser.
`timescale 1ns / 1ps
`default_nettype none
module anp_front import anp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] data_byte,
	input  wire logic       stream_end,
	input  wire logic       tok_pop,
	output logic            tok_empty,
	output tok_t            tok
);

	tok_t                 tok_mem_q [TOK_DEPTH];
	logic [TOK_PTR_W-1:0] wr_ptr_q;
	logic [TOK_PTR_W-1:0] rd_ptr_q;
	logic [TOK_CNT_W-1:0] cnt_q;
	tok_t                 cls;
	logic                 wr_en;
	logic                 rd_en;
	logic                 lead;
	logic                 digit;

	always_comb begin
		lead  = ((data_byte >= 8'h41) && (data_byte <= 8'h5A)) || (data_byte == 8'h5F);
		digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
		cls.data       = data_byte;
		cls.stream_end = stream_end;
		cls.is_lead    = lead;
		cls.is_segch   = lead | digit;
		if (data_byte == ROOT_BYTE) begin
			cls.kind = KIND_ROOT;
		end else if (data_byte == PARENT_BYTE) begin
			cls.kind = KIND_PARENT;
		end else if (data_byte == DUAL_NAME_BYTE) begin
			cls.kind = KIND_DUAL;
		end else if (data_byte == MULTI_NAME_BYTE) begin
			cls.kind = KIND_MULTI;
		end else if (data_byte == NULL_NAME_BYTE) begin
			cls.kind = KIND_NULL;
		end else if (lead) begin
			cls.kind = KIND_LEAD;
		end else begin
			cls.kind = KIND_OTHER;
		end
	end

	assign full      = (cnt_q == TOK_CNT_W'(TOK_DEPTH));
	assign tok_empty = (cnt_q == '0);
	assign wr_en     = push & ~full;
	assign rd_en     = tok_pop & ~tok_empty;
	assign tok       = tok_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tok_mem_q[wr_ptr_q] <= cls;
		end
	end

endmodule
`default_nettype wire

// ----- src/anp_back.sv -----
// Back end: name string state machine and result queue.
`timescale 1ns / 1ps
`default_nettype none
module anp_back import anp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic tok_empty,
	input  wire tok_t tok,
	output logic      tok_pop,
	output logic      empty,
	input  wire logic pop,
	output res_t      res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ROOT,
		PH_PARENTS,
		PH_COUNT,
		PH_SEGS
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        root_q, root_d;
	logic [7:0]  parents_q, parents_d;
	logic [7:0]  total_q, total_d;
	logic [7:0]  pos_q, pos_d;
	logic [1:0]  bis_q, bis_d;
	logic [23:0] partial_q, partial_d;
	logic        seg_ok_q, seg_ok_d;
	logic        bad_q, bad_d;

	res_t                 res_mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] res_wr_ptr_q;
	logic [RES_PTR_W-1:0] res_rd_ptr_q;
	logic [RES_CNT_W-1:0] res_cnt_q;

	res_t res_new;
	logic emit;
	logic do_clear;
	logic do_count;
	logic seg_valid;
	logic seg_last;
	logic res_pop;
	logic res_space;
	logic fire;

	assign empty     = (res_cnt_q == '0);
	assign res_pop   = pop & ~empty;
	assign res_space = (res_cnt_q != RES_CNT_W'(RES_DEPTH)) | res_pop;
	assign fire      = ~tok_empty & res_space;
	assign tok_pop   = fire;
	assign res       = res_mem_q[res_rd_ptr_q];

	always_comb begin
		phase_d   = phase_q;
		root_d    = root_q;
		parents_d = parents_q;
		total_d   = total_q;
		pos_d     = pos_q;
		bis_d     = bis_q;
		partial_d = partial_q;
		seg_ok_d  = seg_ok_q;
		bad_d     = bad_q;
		emit      = 1'b0;
		do_clear  = 1'b0;
		do_count  = 1'b0;
		seg_valid = seg_ok_q & tok.is_segch;
		seg_last  = ({1'b0, pos_q} + 9'd1) >= {1'b0, total_q};

		res_new.root_flag     = root_q;
		res_new.parent_count  = parents_q;
		res_new.segment_count = total_q;
		res_new.segment_index = pos_q;
		res_new.segment_chars = '0;
		res_new.has_segment   = 1'b0;
		res_new.segment_valid = 1'b0;
		res_new.last_of_name  = 1'b1;
		res_new.status        = ST_OK;

		if (tok.stream_end) begin
			if (phase_q != PH_IDLE) begin
				emit           = 1'b1;
				do_clear       = 1'b1;
				res_new.status = ST_TRUNC;
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					case (tok.kind)
						KIND_ROOT: begin
							root_d  = 1'b1;
							phase_d = PH_ROOT;
						end
						KIND_PARENT: begin
							parents_d = 8'd1;
							phase_d   = PH_PARENTS;
						end
						KIND_OTHER: begin
							emit                  = 1'b1;
							do_clear              = 1'b1;
							res_new.root_flag     = 1'b0;
							res_new.parent_count  = '0;
							res_new.segment_count = '0;
							res_new.segment_index = '0;
							res_new.status        = ST_NOT_NAME;
						end
						default: begin
							do_count = 1'b1;
						end
					endcase
				end
				PH_ROOT: begin
					do_count = 1'b1;
				end
				PH_PARENTS: begin
					if (tok.kind == KIND_PARENT) begin
						if (parents_q != 8'hFF) begin
							parents_d = parents_q + 8'd1;
						end
					end else begin
						do_count = 1'b1;
					end
				end
				PH_COUNT: begin
					total_d = tok.data;
					if (tok.data == 8'h00) begin
						emit                  = 1'b1;
						do_clear              = 1'b1;
						res_new.segment_count = '0;
					end else begin
						phase_d = PH_SEGS;
					end
				end
				PH_SEGS: begin
					if (bis_q != 2'd3) begin
						case (bis_q)
							2'd0: partial_d[7:0] = tok.data;
							2'd1: partial_d[15:8] = tok.data;
							default: partial_d[23:16] = tok.data;
						endcase
						seg_ok_d = (bis_q == 2'd0) ? tok.is_lead : (seg_ok_q & tok.is_segch);
						bis_d    = bis_q + 2'd1;
					end else begin
						emit                  = 1'b1;
						res_new.has_segment   = 1'b1;
						res_new.segment_chars = {tok.data, partial_q};
						res_new.segment_valid = seg_valid;
						res_new.last_of_name  = seg_last;
						bad_d                 = bad_q | ~seg_valid;
						if (seg_last) begin
							do_clear       = 1'b1;
							res_new.status = (bad_q | ~seg_valid) ? ST_BAD_CHAR : ST_OK;
						end else begin
							pos_d = pos_q + 8'd1;
							bis_d = 2'd0;
						end
					end
				end
				default: begin
					do_clear = 1'b1;
				end
			endcase

			if (do_count) begin
				case (tok.kind)
					KIND_DUAL: begin
						total_d = 8'd2;
						phase_d = PH_SEGS;
					end
					KIND_MULTI: begin
						phase_d = PH_COUNT;
					end
					KIND_NULL: begin
						emit                  = 1'b1;
						do_clear              = 1'b1;
						res_new.segment_count = '0;
					end
					default: begin
						total_d        = 8'd1;
						phase_d        = PH_SEGS;
						partial_d[7:0] = tok.data;
						seg_ok_d       = tok.is_lead;
						bis_d          = 2'd1;
					end
				endcase
			end
		end

		if (do_clear) begin
			phase_d   = PH_IDLE;
			root_d    = 1'b0;
			parents_d = '0;
			total_d   = '0;
			pos_d     = '0;
			bis_d     = '0;
			partial_d = '0;
			seg_ok_d  = 1'b0;
			bad_d     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			root_q    <= 1'b0;
			parents_q <= '0;
			total_q   <= '0;
			pos_q     <= '0;
			bis_q     <= '0;
			partial_q <= '0;
			seg_ok_q  <= 1'b0;
			bad_q     <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_d;
			root_q    <= root_d;
			parents_q <= parents_d;
			total_q   <= total_d;
			pos_q     <= pos_d;
			bis_q     <= bis_d;
			partial_q <= partial_d;
			seg_ok_q  <= seg_ok_d;
			bad_q     <= bad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_ptr_q <= '0;
			res_rd_ptr_q <= '0;
			res_cnt_q    <= '0;
		end else begin
			if (fire && emit) begin
				res_wr_ptr_q <= res_wr_ptr_q + 1'b1;
			end
			if (res_pop) begin
				res_rd_ptr_q <= res_rd_ptr_q + 1'b1;
			end
			if ((fire && emit) && !res_pop) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end else if (!(fire && emit) && res_pop) begin
				res_cnt_q <= res_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_mem_q[res_wr_ptr_q] <= res_new;
		end
	end

endmodule
`default_nettype wire

// ----- src/aml_name_string_parser_top.sv -----
// Top level of the AML name string parser.
//
//   Channel   Direction  Handshake     Payload
//   input     in         push / full   data_byte, stream_end
//   result    out        empty / pop   root_flag ... status
//
// One byte is taken per cycle while full is low; the parser state machine
// handles one queued item per cycle while the result queue has room, so the
// sustained rate is one byte per clock. Each byte is registered in the byte
// queue; any result it yields is registered in the result queue when parsed.
// Reset clears both queues and the parser state; no clearing pass is needed.
// A stalled result side holds the two-entry result queue, and the four-entry
// byte queue then fills before full is raised.
`timescale 1ns / 1ps
`default_nettype none
module aml_name_string_parser_top import anp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        stream_end,
	output logic             empty,
	input  wire logic        pop,
	output logic             root_flag,
	output logic [7:0]       parent_count,
	output logic [7:0]       segment_count,
	output logic [7:0]       segment_index,
	output logic [31:0]      segment_chars,
	output logic             has_segment,
	output logic             segment_valid,
	output logic             last_of_name,
	output logic [1:0]       status
);

	tok_t tok;
	logic tok_empty;
	logic tok_pop;
	res_t res;

	anp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.data_byte  (data_byte),
		.stream_end (stream_end),
		.tok_pop    (tok_pop),
		.tok_empty  (tok_empty),
		.tok        (tok)
	);

	anp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_empty (tok_empty),
		.tok       (tok),
		.tok_pop   (tok_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign root_flag     = res.root_flag;
	assign parent_count  = res.parent_count;
	assign segment_count = res.segment_count;
	assign segment_index = res.segment_index;
	assign segment_chars = res.segment_chars;
	assign has_segment   = res.has_segment;
	assign segment_valid = res.segment_valid;
	assign last_of_name  = res.last_of_name;
	assign status        = res.status;

	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (res.status != ST_OK)) |-> last_of_name)
		else $error("Nonzero status on an item that does not end the name.");

	a_no_seg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !has_segment) |-> ((segment_chars == 32'h0) && !segment_valid))
		else $error("Item without a segment carries segment data.");

	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && has_segment && !segment_valid && last_of_name)
		|-> (res.status == ST_BAD_CHAR))
		else $error("Final invalid segment does not report a bad character.");

	a_not_name: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (res.status == ST_NOT_NAME))
		|-> (!root_flag && (parent_count == 8'h0) && (segment_count == 8'h0)))
		else $error("Not-a-name item carries name fields.");

endmodule
`default_nettype wire

// ----- sim/anp_result_checker.sv -----
// Checker for the AML name string parser: predicts each result and compares it with the block.
`timescale 1ns / 1ps
module anp_result_checker import anp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        stream_end,
	input  logic        empty,
	input  logic        pop,
	input  logic        root_flag,
	input  logic [7:0]  parent_count,
	input  logic [7:0]  segment_count,
	input  logic [7:0]  segment_index,
	input  logic [31:0] segment_chars,
	input  logic        has_segment,
	input  logic        segment_valid,
	input  logic        last_of_name,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          results_checked,
	output int          results_pending
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_ROOT,
		PH_PARENTS,
		PH_COUNT,
		PH_SEGS
	} parse_phase_t;

	parse_phase_t phase;
	logic         root_seen;
	logic [7:0]   parents_seen;
	logic [7:0]   segments_total;
	logic [7:0]   segment_pos;
	logic [1:0]   byte_pos;
	logic [23:0]  partial_chars;
	logic         bad_seen;
	res_t         name_results[$];

	function automatic logic is_lead_char(logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
	endfunction

	function automatic logic is_name_char(logic [7:0] b);
		return is_lead_char(b) || (b >= 8'h30 && b <= 8'h39);
	endfunction

	function automatic void clear_name();
		phase = PH_IDLE;
		root_seen = 1'b0;
		parents_seen = '0;
		segments_total = '0;
		segment_pos = '0;
		byte_pos = '0;
		partial_chars = '0;
		bad_seen = 1'b0;
	endfunction

	function automatic void emit_result(logic has, logic [31:0] chars, logic valid, logic last,
		status_t st);
		res_t r;
		r.root_flag = root_seen;
		r.parent_count = parents_seen;
		r.segment_count = segments_total;
		r.segment_index = segment_pos;
		r.segment_chars = chars;
		r.has_segment = has;
		r.segment_valid = valid;
		r.last_of_name = last;
		r.status = st;
		name_results.push_back(r);
	endfunction

	function automatic void take_segment_byte(logic [7:0] b);
		logic [31:0] chars;
		logic        valid;
		logic        last;
		if (byte_pos != 2'd3) begin
			partial_chars[8*byte_pos +: 8] = b;
			byte_pos++;
			return;
		end
		chars = {b, partial_chars};
		valid = is_lead_char(chars[7:0]) && is_name_char(chars[15:8]) &&
			is_name_char(chars[23:16]) && is_name_char(b);
		if (!valid)
			bad_seen = 1'b1;
		last = (int'(segment_pos) + 1 >= int'(segments_total));
		emit_result(1'b1, chars, valid, last, last ? (bad_seen ? ST_BAD_CHAR : ST_OK) : ST_OK);
		if (last) begin
			clear_name();
		end else begin
			segment_pos++;
			byte_pos = '0;
			partial_chars = '0;
		end
	endfunction

	function automatic void take_name_start(logic [7:0] b);
		case (b)
			DUAL_NAME_BYTE: begin
				segments_total = 8'd2;
				phase = PH_SEGS;
			end
			MULTI_NAME_BYTE: begin
				phase = PH_COUNT;
			end
			NULL_NAME_BYTE: begin
				segments_total = '0;
				emit_result(1'b0, '0, 1'b0, 1'b1, ST_OK);
				clear_name();
			end
			default: begin
				segments_total = 8'd1;
				phase = PH_SEGS;
				take_segment_byte(b);
			end
		endcase
	endfunction

	function automatic void predict_name_step(logic [7:0] b, logic eos);
		if (phase == PH_IDLE) begin
			if (eos)
				return;
			if (b == ROOT_BYTE) begin
				root_seen = 1'b1;
				phase = PH_ROOT;
			end else if (b == PARENT_BYTE) begin
				parents_seen = 8'd1;
				phase = PH_PARENTS;
			end else if (b == DUAL_NAME_BYTE || b == MULTI_NAME_BYTE || b == NULL_NAME_BYTE ||
				is_lead_char(b)) begin
				take_name_start(b);
			end else begin
				emit_result(1'b0, '0, 1'b0, 1'b1, ST_NOT_NAME);
				clear_name();
			end
			return;
		end
		if (eos) begin
			emit_result(1'b0, '0, 1'b0, 1'b1, ST_TRUNC);
			clear_name();
			return;
		end
		case (phase)
			PH_ROOT: begin
				take_name_start(b);
			end
			PH_PARENTS: begin
				if (b == PARENT_BYTE) begin
					if (parents_seen != 8'hFF)
						parents_seen++;
				end else begin
					take_name_start(b);
				end
			end
			PH_COUNT: begin
				segments_total = b;
				if (b == 8'd0) begin
					emit_result(1'b0, '0, 1'b0, 1'b1, ST_OK);
					clear_name();
				end else begin
					phase = PH_SEGS;
				end
			end
			default: begin
				take_segment_byte(b);
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want_val);
		if (fail_count < 50)
			$display("[%0t] result %0d: %s is %0h, predicted %0h", $time, results_checked,
				what, got, want_val);
		fail_count++;
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want_val);
		if (got !== want_val)
			report_mismatch(what, got, want_val);
	endtask

	task automatic check_result();
		res_t want;
		if (name_results.size() == 0) begin
			report_mismatch("unpredicted result, chars", segment_chars, '0);
			return;
		end
		want = name_results.pop_front();
		results_checked++;
		check_field("root_flag", root_flag, want.root_flag);
		check_field("parent_count", parent_count, want.parent_count);
		check_field("segment_count", segment_count, want.segment_count);
		check_field("segment_index", segment_index, want.segment_index);
		check_field("segment_chars", segment_chars, want.segment_chars);
		check_field("has_segment", has_segment, want.has_segment);
		check_field("segment_valid", segment_valid, want.segment_valid);
		check_field("last_of_name", last_of_name, want.last_of_name);
		check_field("status", status, want.status);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_name();
			name_results.delete();
			fail_count = 0;
			results_checked = 0;
			results_pending = 0;
		end else begin
			if (pop && !empty)
				check_result();
			if (push && !full)
				predict_name_step(data_byte, stream_end);
			results_pending = name_results.size();
		end
	end

endmodule

// ----- sim/aml_name_string_parser_top_tb.sv -----
// Testbench top for the AML name string parser: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module aml_name_string_parser_top_tb;
	import anp_pkg::*;

	localparam int ITEM_TARGET = 800;
	localparam int IDLE_LIMIT  = 5000;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
	} stream_item_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        stream_end;
	logic        empty;
	logic        pop;
	logic        root_flag;
	logic [7:0]  parent_count;
	logic [7:0]  segment_count;
	logic [7:0]  segment_index;
	logic [31:0] segment_chars;
	logic        has_segment;
	logic        segment_valid;
	logic        last_of_name;
	logic [1:0]  status;

	int fail_count;
	int results_checked;
	int results_pending;

	stream_item_t byte_stream[$];
	logic [7:0]   name_bytes[$];
	int           counted_items;
	int           names_built;
	int           truncated_names;
	int           bytes_sent;

	aml_name_string_parser_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.stream_end    (stream_end),
		.empty         (empty),
		.pop           (pop),
		.root_flag     (root_flag),
		.parent_count  (parent_count),
		.segment_count (segment_count),
		.segment_index (segment_index),
		.segment_chars (segment_chars),
		.has_segment   (has_segment),
		.segment_valid (segment_valid),
		.last_of_name  (last_of_name),
		.status        (status)
	);

	anp_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.data_byte       (data_byte),
		.stream_end      (stream_end),
		.empty           (empty),
		.pop             (pop),
		.root_flag       (root_flag),
		.parent_count    (parent_count),
		.segment_count   (segment_count),
		.segment_index   (segment_index),
		.segment_chars   (segment_chars),
		.has_segment     (has_segment),
		.segment_valid   (segment_valid),
		.last_of_name    (last_of_name),
		.status          (status),
		.fail_count      (fail_count),
		.results_checked (results_checked),
		.results_pending (results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void add_byte(logic [7:0] b, logic eos = 1'b0);
		byte_stream.push_back('{data: b, eos: eos});
		counted_items++;
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic logic [7:0] rand_lead_char();
		int k;
		k = $urandom_range(0, 26);
		return (k == 26) ? 8'h5F : 8'(8'h41 + k);
	endfunction

	function automatic logic [7:0] rand_name_char();
		if ($urandom_range(0, 3) == 0)
			return 8'(8'h30 + $urandom_range(0, 9));
		return rand_lead_char();
	endfunction

	function automatic void add_segment(bit clean);
		logic [7:0] b;
		for (int i = 0; i < 4; i++) begin
			if (!clean && $urandom_range(0, 3) == 0)
				b = 8'($urandom_range(0, 255));
			else
				b = (i == 0) ? rand_lead_char() : rand_name_char();
			name_bytes.push_back(b);
		end
	endfunction

	// Builds one name string, mostly well formed, and sometimes cuts it short.
	function automatic void add_random_name(int name_no);
		bit clean;
		int parents;
		int form;
		int count;
		int cut;
		name_bytes.delete();
		clean = ($urandom_range(0, 5) != 0);
		parents = 0;
		case ($urandom_range(0, 3))
			0: name_bytes.push_back(ROOT_BYTE);
			1: parents = $urandom_range(1, 3);
			default: ;
		endcase
		if (name_no == 3 || $urandom_range(0, 59) == 0)
			parents = $urandom_range(250, 300);
		repeat (parents)
			name_bytes.push_back(PARENT_BYTE);
		form = $urandom_range(0, 9);
		if (name_no == 7) begin
			name_bytes.push_back(MULTI_NAME_BYTE);
			name_bytes.push_back(8'd120);
			repeat (120)
				add_segment(clean);
		end else if (form <= 3) begin
			add_segment(clean);
		end else if (form <= 5) begin
			name_bytes.push_back(DUAL_NAME_BYTE);
			add_segment(clean);
			add_segment(clean);
		end else if (form <= 8) begin
			count = ($urandom_range(0, 119) == 0) ? $urandom_range(100, 255) :
				$urandom_range(1, 6);
			name_bytes.push_back(MULTI_NAME_BYTE);
			name_bytes.push_back(8'(count));
			repeat (count)
				add_segment(clean);
		end else if ($urandom_range(0, 1) == 0) begin
			name_bytes.push_back(NULL_NAME_BYTE);
		end else begin
			name_bytes.push_back(MULTI_NAME_BYTE);
			name_bytes.push_back(8'd0);
		end
		cut = name_bytes.size();
		if (name_bytes.size() > 1 && $urandom_range(0, 7) == 0) begin
			cut = $urandom_range(1, name_bytes.size() - 1);
			truncated_names++;
		end
		for (int i = 0; i < cut; i++)
			add_byte(name_bytes[i]);
		if (cut != name_bytes.size())
			add_byte(8'($urandom_range(0, 255)), 1'b1);
		names_built++;
	endfunction

	function automatic void build_stimulus();
		int name_no;
		add_byte(8'hFF);
		byte_stream.push_back('{data: 8'h00, eos: 1'b1});
		add_byte(NULL_NAME_BYTE);
		add_text("ABCD");
		add_byte(ROOT_BYTE);
		add_byte(DUAL_NAME_BYTE);
		add_text("_Z9_");
		add_text("A-01");
		add_byte(PARENT_BYTE);
		add_byte(PARENT_BYTE);
		add_byte(MULTI_NAME_BYTE);
		add_byte(8'd0);
		add_byte(ROOT_BYTE);
		add_byte(PARENT_BYTE);
		add_text("BCD");
		add_byte(PARENT_BYTE);
		add_text("1A");
		add_byte(8'hA5, 1'b1);
		name_no = 0;
		while (counted_items < ITEM_TARGET) begin
			case ($urandom_range(0, 11))
				0: add_byte(8'($urandom_range(0, 255)));
				1: byte_stream.push_back('{data: 8'($urandom_range(0, 255)), eos: 1'b1});
				default: begin
					add_random_name(name_no);
					name_no++;
				end
			endcase
		end
	endfunction

	initial begin
		int burst_left;
		int gap;
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = '0;
		stream_end = 1'b0;
		counted_items = 0;
		names_built = 0;
		truncated_names = 0;
		bytes_sent = 0;
		build_stimulus();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		burst_left = 0;
		foreach (byte_stream[i]) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 32);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					push <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			push <= 1'b1;
			data_byte <= byte_stream[i].data;
			stream_end <= byte_stream[i].eos;
			@(posedge clk);
			while (full)
				@(posedge clk);
			@(negedge clk);
			burst_left--;
			bytes_sent++;
		end
		push <= 1'b0;
		while (results_pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Drove %0d bytes forming %0d name strings, %0d of them cut short by a stream end.",
			bytes_sent, names_built, truncated_names);
		$display("Compared %0d parser results field by field, %0d mismatches.",
			results_checked, fail_count);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int mode;
		int mode_left;
		pop = 1'b0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(8, 64);
			end
			mode_left--;
			case (mode)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 3) != 0);
				2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= ((mode_left % 12) < 3);
			endcase
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Timeout: no item moved for %0d cycles, %0d results still predicted.",
			IDLE_LIMIT, results_pending);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- aml_name_string_parser_top.f -----
src/anp_pkg.sv
src/anp_front.sv
src/anp_back.sv
src/aml_name_string_parser_top.sv
sim/anp_result_checker.sv
sim/aml_name_string_parser_top_tb.sv
